[rtl/pcr_pkg.sv]
// Shared types, constants and the divider step function for the palette colormap remap block.
package pcr_pkg;

  // Default palette depth
  localparam int PALETTE_DEPTH_DEF = 256;

  // Quotient bits resolved per divider stage, and the number of such stages
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 16 / DIV_BITS;

  // Rec.709 luminance weights, Q0.16
  localparam logic [15:0] LUMA_R = 16'd13933;
  localparam logic [15:0] LUMA_G = 16'd46871;
  localparam logic [15:0] LUMA_B = 16'd4732;

  // Unity in Q1.16 and the rounding bias
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SELECT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 8'd3;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Source select codes
  localparam logic SRC_RED  = 1'b0;
  localparam logic SRC_LUMA = 1'b1;

  // One color, red in the lowest bits
  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  // Input item as it travels down the pipe
  typedef struct packed {
    logic       cmd;
    logic [7:0] idx;
    rgb_t       rgb;
  } item_t;

  // Divider state: zero and saturate flags, divisor, partial remainder, quotient
  typedef struct packed {
    logic        zero;
    logic        sat;
    logic [15:0] den;
    logic [15:0] rem;
    logic [15:0] quo;
  } div_t;

  // Restoring division, DIV_BITS quotient bits
  function automatic div_t div_step(div_t d);
    div_t        r;
    logic [16:0] sh;
    r = d;
    for (int i = 0; i < DIV_BITS; i++) begin
      sh = {r.rem, 1'b0};
      if (sh >= {1'b0, r.den}) begin
        r.rem = 16'(sh - {1'b0, r.den});
        r.quo = {r.quo[14:0], 1'b1};
      end else begin
        r.rem = sh[15:0];
        r.quo = {r.quo[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[rtl/palette_colormap_remap.sv]
// A pixel's result passes through 12 register stages from its input transfer to the output.
// Throughput: one item per cycle while m_tready does not stall the output; the divider resolves
// 4 quotient bits in each of 4 stages and the palette is read at both neighbor entries at once.
// Palette writes take no output slot and land in the palette at the RAM stage, in order.
// Reset clears pipeline valid bits and sets source_select=0, range 0..65535, count=2;
// palette contents are undefined until written.
module palette_colormap_remap #(
  parameter int PALETTE_DEPTH = pcr_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [55:0]                   s_tdata,   // entry_index, red, green, blue
  input  logic [0:0]                    s_tuser,   // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // mapped_red, mapped_green, mapped_blue
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int XW    = 17 + IDX_W;
  localparam int NS    = 12;

  // Configuration registers
  logic        src_sel;
  logic [15:0] range_low;
  logic [15:0] range_high;
  logic [8:0]  pal_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_sel    <= pcr_pkg::SRC_RED;
      range_low  <= 16'd0;
      range_high <= 16'hFFFF;
      pal_count  <= 9'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcr_pkg::REG_SOURCE_SELECT: src_sel    <= cfg_data[0];
        pcr_pkg::REG_RANGE_LOW:     range_low  <= cfg_data;
        pcr_pkg::REG_RANGE_HIGH:    range_high <= cfg_data;
        pcr_pkg::REG_PALETTE_COUNT: pal_count  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Entry count saturated to 2..depth, as n-1 and n-2
  logic [31:0]      n_sat;
  logic [IDX_W-1:0] nm1;
  logic [IDX_W-1:0] nm2;

  always_comb begin
    if (pal_count < 9'd2) begin
      n_sat = 32'd2;
    end else if (32'(pal_count) > 32'(PALETTE_DEPTH)) begin
      n_sat = 32'(PALETTE_DEPTH);
    end else begin
      n_sat = 32'(pal_count);
    end
    nm1 = IDX_W'(n_sat - 32'd1);
    nm2 = IDX_W'(n_sat - 32'd2);
  end

  // Stage valids and load enables; a stage loads when empty or draining
  logic [NS:1] vld;
  logic [NS:1] vin;
  logic [NS:1] ld;

  always_comb begin
    ld[NS] = !vld[NS] || m_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  pcr_pkg::item_t it [1:9];

  always_comb begin
    vin[1] = s_tvalid;
    for (int k = 2; k <= NS; k++) begin
      vin[k] = vld[k-1];
    end
    // palette writes leave the pipe at the RAM stage
    vin[10] = vld[9] && (it[9].cmd == pcr_pkg::CMD_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (ld[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  assign s_tready = ld[1];
  assign m_tvalid = vld[NS];

  // Item carried through stage 9 for writes and the command bit
  pcr_pkg::item_t it_in;

  always_comb begin
    it_in.cmd       = s_tuser[0];
    it_in.idx       = s_tdata[7:0];
    it_in.rgb.red   = s_tdata[23:8];
    it_in.rgb.green = s_tdata[39:24];
    it_in.rgb.blue  = s_tdata[55:40];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      it[1] <= it_in;
    end
    for (int k = 2; k <= 9; k++) begin
      if (ld[k]) begin
        it[k] <= it[k-1];
      end
    end
  end

  // Stage 1: luminance products
  logic [31:0] prod_r;
  logic [31:0] prod_g;
  logic [31:0] prod_b;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      prod_r <= 32'(pcr_pkg::LUMA_R) * 32'(it_in.rgb.red);
      prod_g <= 32'(pcr_pkg::LUMA_G) * 32'(it_in.rgb.green);
      prod_b <= 32'(pcr_pkg::LUMA_B) * 32'(it_in.rgb.blue);
    end
  end

  // Stage 2: scalar value
  logic [33:0] luma_sum;
  logic [15:0] luma;
  logic [15:0] val2;

  always_comb begin
    luma_sum = 34'(prod_r) + 34'(prod_g) + 34'(prod_b) + 34'(pcr_pkg::HALF_Q16);
    luma     = (luma_sum[33:32] != 2'd0) ? 16'hFFFF : luma_sum[31:16];
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      val2 <= (src_sel == pcr_pkg::SRC_LUMA) ? luma : it[1].rgb.red;
    end
  end

  // Stage 3: magnitudes and special cases of the normalizing divide
  pcr_pkg::div_t dv [0:pcr_pkg::DIV_STAGES];
  pcr_pkg::div_t dv_next;
  logic          num_pos;
  logic          den_pos;
  logic [15:0]   num_abs;
  logic [15:0]   den_abs;

  always_comb begin
    num_pos = val2 > range_low;
    den_pos = range_high > range_low;
    num_abs = num_pos ? (val2 - range_low) : (range_low - val2);
    den_abs = den_pos ? (range_high - range_low) : (range_low - range_high);
    dv_next.zero = (val2 == range_low) || (range_high == range_low) || (num_pos != den_pos);
    dv_next.sat  = num_abs >= den_abs;
    dv_next.den  = den_abs;
    dv_next.rem  = num_abs;
    dv_next.quo  = 16'd0;
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      dv[0] <= dv_next;
    end
  end

  // Stages 4 to 7: quotient bits
  for (genvar g = 0; g < pcr_pkg::DIV_STAGES; g++) begin : g_div
    pcr_div_stage u_div (
      .clk   (clk),
      .en    (ld[4+g]),
      .d_in  (dv[g]),
      .d_out (dv[g+1])
    );
  end

  // Stage 8: position t scaled by n-1
  logic [16:0]   t_pos;
  logic [XW-1:0] x8;

  always_comb begin
    if (dv[pcr_pkg::DIV_STAGES].zero) begin
      t_pos = 17'd0;
    end else if (dv[pcr_pkg::DIV_STAGES].sat) begin
      t_pos = pcr_pkg::ONE_Q16;
    end else begin
      t_pos = {1'b0, dv[pcr_pkg::DIV_STAGES].quo};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      x8 <= XW'(t_pos) * XW'(nm1);
    end
  end

  // Stage 9: entry index and blend weight
  logic [IDX_W:0]   x_int;
  logic             ix_clamp;
  logic [IDX_W-1:0] ix9;
  logic [16:0]      w9;
  logic [16:0]      wi9;

  always_comb begin
    x_int    = x8[XW-1:16];
    ix_clamp = x_int > {1'b0, nm2};
  end

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      ix9 <= ix_clamp ? nm2 : x_int[IDX_W-1:0];
      w9  <= ix_clamp ? pcr_pkg::ONE_Q16 : {1'b0, x8[15:0]};
      wi9 <= ix_clamp ? 17'd0 : (pcr_pkg::ONE_Q16 - {1'b0, x8[15:0]});
    end
  end

  // Stage 10: palette access, writes and reads in item order
  logic          wr_ok;
  logic          pal_we;
  logic          pal_re;
  pcr_pkg::rgb_t pal_a;
  pcr_pkg::rgb_t pal_b;
  logic [16:0]   w10;
  logic [16:0]   wi10;

  assign wr_ok  = 32'(it[9].idx) < 32'(PALETTE_DEPTH);
  assign pal_we = ld[10] && vld[9] && (it[9].cmd == pcr_pkg::CMD_WRITE) && wr_ok;
  assign pal_re = ld[10] && vld[9] && (it[9].cmd == pcr_pkg::CMD_PIXEL);

  pcr_palette_ram #(
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (IDX_W'(it[9].idx)),
    .wdata   (it[9].rgb),
    .re      (pal_re),
    .raddr_a (ix9),
    .raddr_b (ix9 + IDX_W'(1)),
    .rdata_a (pal_a),
    .rdata_b (pal_b)
  );

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      w10  <= w9;
      wi10 <= wi9;
    end
  end

  // Stage 11: weighted channel products
  logic [32:0] prod_a [3];
  logic [32:0] prod_b2 [3];

  always_ff @(posedge clk) begin
    if (ld[11]) begin
      for (int c = 0; c < 3; c++) begin
        prod_a[c]  <= 33'(pal_a[16*c +: 16]) * 33'(wi10);
        prod_b2[c] <= 33'(pal_b[16*c +: 16]) * 33'(w10);
      end
    end
  end

  // Stage 12: rounded blend, output register
  logic [33:0] blend [3];
  logic [47:0] out12;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend[c] = 34'(prod_a[c]) + 34'(prod_b2[c]) + 34'(pcr_pkg::HALF_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[12]) begin
      for (int c = 0; c < 3; c++) begin
        out12[16*c +: 16] <= blend[c][31:16];
      end
    end
  end

  assign m_tdata = out12;

`ifndef SYNTHESIS
  // Non-saturating divides start with a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !dv[0].zero && !dv[0].sat |-> dv[0].rem < dv[0].den)
    else $error("divider remainder not below divisor");

  // The lower neighbor never passes n-2
  a_ix_range: assert property (@(posedge clk) disable iff (rst)
    vld[9] && (it[9].cmd == pcr_pkg::CMD_PIXEL) |-> ix9 <= nm2)
    else $error("palette index out of range");

  // Blend weights are complementary and at most one
  a_weight: assert property (@(posedge clk) disable iff (rst)
    vld[9] |-> (w9 <= pcr_pkg::ONE_Q16) && (18'(w9) + 18'(wi9) == 18'(pcr_pkg::ONE_Q16)))
    else $error("blend weights inconsistent");

  // Only pixel items get past the palette stage
  a_no_write_out: assert property (@(posedge clk) disable iff (rst)
    ld[10] && vld[9] && (it[9].cmd == pcr_pkg::CMD_WRITE) |=> !vld[10])
    else $error("palette write produced a result");
`endif

endmodule

[rtl/pcr_div_stage.sv]
// One registered stage of the pipelined normalizing divider.
module pcr_div_stage (
  input  logic           clk,
  input  logic           en,
  input  pcr_pkg::div_t  d_in,
  output pcr_pkg::div_t  d_out
);

  // Resolve the next group of quotient bits
  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= pcr_pkg::div_step(d_in);
    end
  end

endmodule

[rtl/pcr_palette_ram.sv]
// Palette storage: one write port, two registered read ports.
module pcr_palette_ram #(
  parameter int DEPTH = pcr_pkg::PALETTE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pcr_pkg::rgb_t wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output pcr_pkg::rgb_t rdata_a,
  output pcr_pkg::rgb_t rdata_b
);

  pcr_pkg::rgb_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
